// ===== rtl/hmcs_pkg.sv =====
package hmcs_pkg;

    localparam int CHANNELS_DEF = 4;
    localparam int NUM_POL      = 4;

    localparam int REQ_W   = 3;
    localparam int CHAN_W  = 3;
    localparam int SPEED_W = 16;
    localparam int DIR_W   = 2;
    localparam int DUTY_W  = 16;
    localparam int OCH_W   = 2;
    localparam int RPM_W   = 15;
    localparam int POL_W   = 4;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    localparam int DIV_STEPS = DUTY_W;
    localparam int CNT_W     = $clog2(DIV_STEPS);

    localparam logic [RPM_W-1:0]  RPM_RESET  = RPM_W'(1000);
    localparam logic [DUTY_W-1:0] DUTY_RESET = DUTY_W'(1000);
    localparam logic [POL_W-1:0]  POL_RESET  = '0;

    localparam logic [REQ_W-1:0] REQ_SPEED = 3'd0;
    localparam logic [REQ_W-1:0] REQ_STOP  = 3'd1;
    localparam logic [REQ_W-1:0] REQ_BRAKE = 3'd2;
    localparam logic [REQ_W-1:0] REQ_DIR   = 3'd3;
    localparam logic [REQ_W-1:0] REQ_RAW   = 3'd4;

    localparam logic [CFG_IDX_W-1:0] CFG_MAX_RPM  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PWM_FULL = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_POLARITY = 2'd2;

    localparam logic ACT_DUTY = 1'b0;
    localparam logic ACT_PINS = 1'b1;

    typedef enum logic [1:0] {
        MODE_STOP  = 2'd0,
        MODE_FWD   = 2'd1,
        MODE_BWD   = 2'd2,
        MODE_BRAKE = 2'd3
    } t_mode;

    typedef enum logic [1:0] {
        OSEL_ZERO = 2'd0,
        OSEL_PINS = 2'd1,
        OSEL_DUTY = 2'd2
    } t_osel;

    typedef struct packed {
        logic  load;
        logic  decode;
        logic  mul;
        logic  div_step;
        t_osel out_sel;
        logic  out_last;
    } t_ctrl_cmd;

    typedef struct packed {
        logic              bad;
        logic [REQ_W-1:0]  req;
        logic              spd_zero;
        logic              mode_chg;
        logic              div_last;
    } t_dp_stat;

endpackage

// ===== rtl/hmcs_if.sv =====
interface hmcs_req_if import hmcs_pkg::*; ();
    logic                      valid;
    logic                      ready;
    logic [REQ_W-1:0]          req_type;
    logic [CHAN_W-1:0]         channel;
    logic signed [SPEED_W-1:0] speed;
    logic [DIR_W-1:0]          direction_code;
    logic [DUTY_W-1:0]         duty_value;

    modport source (output valid, req_type, channel, speed, direction_code, duty_value,
                    input ready);
    modport sink   (input valid, req_type, channel, speed, direction_code, duty_value,
                    output ready);
endinterface

interface hmcs_act_if import hmcs_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [OCH_W-1:0]  out_channel;
    logic              action;
    logic [DUTY_W-1:0] duty;
    logic              pin_in1;
    logic              pin_in2;
    logic              last;

    modport source (output valid, out_channel, action, duty, pin_in1, pin_in2, last,
                    input ready);
    modport sink   (input valid, out_channel, action, duty, pin_in1, pin_in2, last,
                    output ready);
endinterface

interface hmcs_cfg_if import hmcs_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// ===== rtl/hmcs_dp.sv =====
module hmcs_dp import hmcs_pkg::*; #(
    parameter int CHANNELS = CHANNELS_DEF
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  t_ctrl_cmd                 i_cmd,
    output t_dp_stat                  o_stat,
    input  logic [REQ_W-1:0]          i_req_type,
    input  logic [CHAN_W-1:0]         i_channel,
    input  logic signed [SPEED_W-1:0] i_speed,
    input  logic [DIR_W-1:0]          i_direction_code,
    input  logic [DUTY_W-1:0]         i_duty_value,
    input  logic                      i_cfg_wr,
    input  logic [CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [CFG_DATA_W-1:0]     i_cfg_data,
    output logic [OCH_W-1:0]          o_out_channel,
    output logic                      o_action,
    output logic [DUTY_W-1:0]         o_duty,
    output logic                      o_pin_in1,
    output logic                      o_pin_in2,
    output logic                      o_last
);

    localparam int MIDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

    // configuration
    logic [RPM_W-1:0]  r_max_rpm;
    logic [DUTY_W-1:0] r_pwm_full;
    logic [POL_W-1:0]  r_pol;

    // latched transaction
    logic [REQ_W-1:0]          r_req;
    logic [CHAN_W-1:0]         r_ch;
    logic signed [SPEED_W-1:0] r_speed;
    logic [DIR_W-1:0]          r_dir;

    t_mode             r_mode [CHANNELS];
    t_mode             r_new_mode;
    logic [RPM_W-1:0]  r_mag;
    logic [RPM_W-1:0]  r_rem;
    logic [DUTY_W-1:0] r_duty;
    logic [CNT_W-1:0]  r_cnt;

    logic [RPM_W-1:0]   rpm;
    logic [MIDX_W-1:0]  midx;
    logic               pol;
    logic [SPEED_W-1:0] spd_abs;
    logic [RPM_W-1:0]   mag_c;
    t_mode              spd_mode;
    t_mode              n_new_mode;
    logic [DUTY_W-1:0]  trial;
    logic               ge;

    assign rpm  = (r_max_rpm == '0) ? RPM_W'(1) : r_max_rpm;
    assign midx = r_ch[MIDX_W-1:0];
    assign pol  = (r_ch < CHAN_W'(NUM_POL)) && r_pol[r_ch[1:0]];

    assign spd_abs  = r_speed[SPEED_W-1] ? SPEED_W'(-r_speed) : SPEED_W'(r_speed);
    assign mag_c    = (spd_abs > {1'b0, rpm}) ? rpm : spd_abs[RPM_W-1:0];
    assign spd_mode = (r_speed[SPEED_W-1] ^ pol) ? MODE_BWD : MODE_FWD;

    always_comb begin
        n_new_mode = MODE_STOP;
        case (r_req)
            REQ_SPEED: n_new_mode = (r_speed == '0) ? MODE_STOP : spd_mode;
            REQ_BRAKE: n_new_mode = MODE_BRAKE;
            REQ_DIR:   n_new_mode = t_mode'(r_dir);
            default:   n_new_mode = MODE_STOP;
        endcase
    end

    // restoring divide step; remainder stays below max_rpm
    assign trial = {r_rem, r_duty[DUTY_W-1]};
    assign ge    = trial >= {1'b0, rpm};

    assign o_stat.bad      = ({1'b0, r_ch} >= (CHAN_W+1)'(CHANNELS)) || (r_req > REQ_RAW);
    assign o_stat.req      = r_req;
    assign o_stat.spd_zero = (r_speed == '0);
    assign o_stat.mode_chg = (spd_mode != r_mode[midx]);
    assign o_stat.div_last = (r_cnt == CNT_W'(DIV_STEPS - 1));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_rpm  <= RPM_RESET;
            r_pwm_full <= DUTY_RESET;
            r_pol      <= POL_RESET;
        end else if (i_cfg_wr) begin
            unique case (i_cfg_index)
                CFG_MAX_RPM:  r_max_rpm  <= i_cfg_data[RPM_W-1:0];
                CFG_PWM_FULL: r_pwm_full <= i_cfg_data[DUTY_W-1:0];
                CFG_POLARITY: r_pol      <= i_cfg_data[POL_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < CHANNELS; i++) begin
                r_mode[i] <= MODE_STOP;
            end
        end else if (i_cmd.decode && (r_req != REQ_RAW)) begin
            r_mode[midx] <= n_new_mode;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_req   <= i_req_type;
            r_ch    <= i_channel;
            r_speed <= i_speed;
            r_dir   <= i_direction_code;
            r_duty  <= i_duty_value;
        end
        if (i_cmd.decode) begin
            r_new_mode <= n_new_mode;
            r_mag      <= mag_c;
        end
        if (i_cmd.mul) begin
            {r_rem, r_duty} <= (RPM_W+DUTY_W)'(r_mag) * (RPM_W+DUTY_W)'(r_pwm_full);
            r_cnt           <= '0;
        end
        if (i_cmd.div_step) begin
            r_rem  <= ge ? RPM_W'(trial - {1'b0, rpm}) : trial[RPM_W-1:0];
            r_duty <= {r_duty[DUTY_W-2:0], ge};
            r_cnt  <= r_cnt + CNT_W'(1);
        end
    end

    assign o_out_channel = r_ch[OCH_W-1:0];
    assign o_action      = (i_cmd.out_sel == OSEL_PINS) ? ACT_PINS : ACT_DUTY;
    assign o_duty        = (i_cmd.out_sel == OSEL_DUTY) ? r_duty : '0;
    assign o_pin_in1     = (i_cmd.out_sel == OSEL_PINS) &&
                           ((r_new_mode == MODE_BWD) || (r_new_mode == MODE_BRAKE));
    assign o_pin_in2     = (i_cmd.out_sel == OSEL_PINS) &&
                           ((r_new_mode == MODE_FWD) || (r_new_mode == MODE_BRAKE));
    assign o_last        = i_cmd.out_last;

endmodule

// ===== rtl/hmcs_ctrl.sv =====
module hmcs_ctrl import hmcs_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_ready,
    output logic      o_out_valid,
    input  logic      i_out_ready,
    input  t_dp_stat  i_stat,
    output t_ctrl_cmd o_cmd
);

    typedef enum logic [8:0] {
        S_IDLE      = 9'b000000001,
        S_DEC       = 9'b000000010,
        S_MUL       = 9'b000000100,
        S_DIV       = 9'b000001000,
        S_ZERO      = 9'b000010000,
        S_PINS_MID  = 9'b000100000,
        S_PINS_LAST = 9'b001000000,
        S_DUTY_LAST = 9'b010000000,
        S_SPARE     = 9'b100000000
    } t_state;

    t_state r_state, n_state;
    logic   r_chg, n_chg;
    logic   out_take;

    assign out_take = o_out_valid && i_out_ready;

    always_comb begin
        n_state = r_state;
        n_chg   = r_chg;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) n_state = S_DEC;
            end
            S_DEC: begin
                if (i_stat.bad) begin
                    n_state = S_IDLE;
                end else begin
                    unique case (i_stat.req) inside
                        REQ_SPEED: begin
                            if (i_stat.spd_zero) begin
                                n_state = S_ZERO;
                                n_chg   = 1'b0;
                            end else begin
                                n_state = S_MUL;
                                n_chg   = i_stat.mode_chg;
                            end
                        end
                        REQ_STOP, REQ_BRAKE: begin
                            n_state = S_ZERO;
                            n_chg   = 1'b0;
                        end
                        REQ_DIR: n_state = S_PINS_LAST;
                        default: n_state = S_DUTY_LAST;
                    endcase
                end
            end
            S_MUL: n_state = S_DIV;
            S_DIV: begin
                if (i_stat.div_last) n_state = r_chg ? S_ZERO : S_DUTY_LAST;
            end
            S_ZERO: begin
                if (out_take) n_state = r_chg ? S_PINS_MID : S_PINS_LAST;
            end
            S_PINS_MID: begin
                if (out_take) n_state = S_DUTY_LAST;
            end
            S_PINS_LAST, S_DUTY_LAST: begin
                if (out_take) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_chg   <= 1'b0;
        end else begin
            r_state <= n_state;
            r_chg   <= n_chg;
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = (r_state == S_ZERO) || (r_state == S_PINS_MID) ||
                         (r_state == S_PINS_LAST) || (r_state == S_DUTY_LAST);

    always_comb begin
        o_cmd          = '0;
        o_cmd.load     = (r_state == S_IDLE) && i_in_valid;
        o_cmd.decode   = (r_state == S_DEC) && !i_stat.bad;
        o_cmd.mul      = (r_state == S_MUL);
        o_cmd.div_step = (r_state == S_DIV);
        o_cmd.out_sel  = OSEL_DUTY;
        if (r_state == S_ZERO) begin
            o_cmd.out_sel = OSEL_ZERO;
        end else if ((r_state == S_PINS_MID) || (r_state == S_PINS_LAST)) begin
            o_cmd.out_sel = OSEL_PINS;
        end
        o_cmd.out_last = (r_state == S_PINS_LAST) || (r_state == S_DUTY_LAST);
    end

endmodule

// ===== rtl/hbridge_motor_command_sequencer.sv =====
// channel  dir  port   contents
// -------  ---  -----  --------------------------------------------------
// command  in   i_req  req_type, channel, speed, direction_code, duty_value
// action   out  o_act  out_channel, action, duty, pin_in1, pin_in2, last
// config   in   i_cfg  index (0 max_rpm, 1 PWM full scale, 2 polarity_mask), data
//
// One command at a time. A nonzero set speed passes through decode, one multiply and
// 16 steps of the shared restoring divider before its first action, then one cycle
// per action; zero speeds and other commands pass decode, then their actions.
// Bad channels and unknown requests drop out after decode with no action.
// A stall on o_act holds the current action; i_req stays not ready until the
// last action of the command has gone. Config writes are always ready.
// Reset is synchronous: all channels stop, registers to their defaults.
module hbridge_motor_command_sequencer import hmcs_pkg::*; #(
    parameter int CHANNELS = CHANNELS_DEF
) (
    input logic         i_clk,
    input logic         i_rst_n,
    hmcs_req_if.sink    i_req,
    hmcs_act_if.source  o_act,
    hmcs_cfg_if.sink    i_cfg
);

    t_ctrl_cmd cmd;
    t_dp_stat  stat;
    logic      in_ready;
    logic      out_valid;

    assign i_req.ready = in_ready;
    assign o_act.valid = out_valid;
    assign i_cfg.ready = 1'b1;

    hmcs_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_req.valid),
        .o_in_ready  (in_ready),
        .o_out_valid (out_valid),
        .i_out_ready (o_act.ready),
        .i_stat      (stat),
        .o_cmd       (cmd)
    );

    hmcs_dp #(
        .CHANNELS (CHANNELS)
    ) u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (cmd),
        .o_stat           (stat),
        .i_req_type       (i_req.req_type),
        .i_channel        (i_req.channel),
        .i_speed          (i_req.speed),
        .i_direction_code (i_req.direction_code),
        .i_duty_value     (i_req.duty_value),
        .i_cfg_wr         (i_cfg.valid),
        .i_cfg_index      (i_cfg.index),
        .i_cfg_data       (i_cfg.data),
        .o_out_channel    (o_act.out_channel),
        .o_action         (o_act.action),
        .o_duty           (o_act.duty),
        .o_pin_in1        (o_act.pin_in1),
        .o_pin_in2        (o_act.pin_in2),
        .o_last           (o_act.last)
    );

endmodule

// ===== dv/testbench.sv =====
module testbench;
    import hmcs_pkg::*;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int SETTLE_CYCLES  = 40;
    localparam int MAX_REPORTS    = 10;
    localparam int BURST_MAX      = 14;
    // index 3 of the register map has no register behind it
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;

    typedef struct packed {
        logic [REQ_W-1:0]   req_type;
        logic [CHAN_W-1:0]  channel;
        logic [SPEED_W-1:0] speed;
        logic [DIR_W-1:0]   direction_code;
        logic [DUTY_W-1:0]  duty_value;
    } t_motor_cmd;

    typedef struct packed {
        logic [OCH_W-1:0]  out_channel;
        logic              action;
        logic [DUTY_W-1:0] duty;
        logic              pin_in1;
        logic              pin_in2;
        logic              last;
    } t_bridge_action;

    logic i_clk = 1'b0;
    logic i_rst_n;

    hmcs_req_if req_bus();
    hmcs_act_if act_bus();
    hmcs_cfg_if cfg_bus();

    hbridge_motor_command_sequencer dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_bus),
        .o_act   (act_bus),
        .i_cfg   (cfg_bus)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // predictor state and register shadow
    t_mode             bridge_state [CHANNELS_DEF];
    logic [RPM_W-1:0]  cfg_max_rpm;
    logic [DUTY_W-1:0] cfg_pwm_full;
    logic [POL_W-1:0]  cfg_polarity;

    t_motor_cmd     command_backlog[$];
    t_bridge_action expected_actions[$];

    int send_gap;
    int hold_left;
    int gap_pct;
    int stall_pct;
    int n_fail;
    int quiet_cycles;

    function automatic void queue_action(logic [CHAN_W-1:0] ch, logic act,
                                         logic [DUTY_W-1:0] duty, t_mode mode,
                                         logic last);
        t_bridge_action a;
        a.out_channel = ch[OCH_W-1:0];
        a.action      = act;
        a.duty        = (act == ACT_PINS) ? '0 : duty;
        a.pin_in1     = (act == ACT_PINS) && (mode == MODE_BWD || mode == MODE_BRAKE);
        a.pin_in2     = (act == ACT_PINS) && (mode == MODE_FWD || mode == MODE_BRAKE);
        a.last        = last;
        expected_actions.push_back(a);
    endfunction

    // PWM off, then the pins for the new mode
    function automatic void halt_channel(logic [CHAN_W-1:0] ch, t_mode mode);
        queue_action(ch, ACT_DUTY, '0, MODE_STOP, 1'b0);
        queue_action(ch, ACT_PINS, '0, mode, 1'b1);
        bridge_state[ch] = mode;
    endfunction

    function automatic void predict_bridge_actions(t_motor_cmd c);
        int signed         rpm_req;
        int unsigned       span;
        int unsigned       magnitude;
        logic [DUTY_W-1:0] duty;
        t_mode             heading;
        if (c.channel >= CHANNELS_DEF)
            return;
        case (c.req_type)
            REQ_SPEED: begin
                rpm_req = int'($signed(c.speed));
                if (cfg_polarity[c.channel[OCH_W-1:0]])
                    rpm_req = -rpm_req;
                span = (cfg_max_rpm == '0) ? 1 : int'(cfg_max_rpm);
                if (rpm_req == 0) begin
                    halt_channel(c.channel, MODE_STOP);
                end else begin
                    heading   = (rpm_req > 0) ? MODE_FWD : MODE_BWD;
                    magnitude = (rpm_req > 0) ? rpm_req : -rpm_req;
                    if (magnitude > span)
                        magnitude = span;
                    duty = DUTY_W'((64'(magnitude) * 64'(cfg_pwm_full)) / 64'(span));
                    if (heading != bridge_state[c.channel]) begin
                        queue_action(c.channel, ACT_DUTY, '0, MODE_STOP, 1'b0);
                        queue_action(c.channel, ACT_PINS, '0, heading, 1'b0);
                        queue_action(c.channel, ACT_DUTY, duty, MODE_STOP, 1'b1);
                        bridge_state[c.channel] = heading;
                    end else begin
                        queue_action(c.channel, ACT_DUTY, duty, MODE_STOP, 1'b1);
                    end
                end
            end
            REQ_STOP:  halt_channel(c.channel, MODE_STOP);
            REQ_BRAKE: halt_channel(c.channel, MODE_BRAKE);
            REQ_DIR: begin
                queue_action(c.channel, ACT_PINS, '0, t_mode'(c.direction_code), 1'b1);
                bridge_state[c.channel] = t_mode'(c.direction_code);
            end
            REQ_RAW:   queue_action(c.channel, ACT_DUTY, c.duty_value, MODE_STOP, 1'b1);
            default: ;
        endcase
    endfunction

    function automatic string describe_action(t_bridge_action a);
        return $sformatf("ch=%0d act=%0d duty=%0d in1=%0d in2=%0d last=%0d",
                         a.out_channel, a.action, a.duty, a.pin_in1, a.pin_in2, a.last);
    endfunction

    function automatic t_motor_cmd make_command(logic [REQ_W-1:0] req, int ch, int speed,
                                                logic [DIR_W-1:0] dir, int duty_val);
        t_motor_cmd c;
        c.req_type       = req;
        c.channel        = CHAN_W'(ch);
        c.speed          = SPEED_W'(speed);
        c.direction_code = dir;
        c.duty_value     = DUTY_W'(duty_val);
        return c;
    endfunction

    // speeds clustered round zero, the clamp point and the 16-bit extremes
    function automatic logic [SPEED_W-1:0] pick_speed();
        int span;
        int v;
        span = (cfg_max_rpm == '0) ? 1 : int'(cfg_max_rpm);
        case ($urandom_range(0, 7))
            0: v = 0;
            1: v = 1;
            2: v = span;
            3: v = span + int'($urandom_range(0, 3)) - 1;
            4: return $urandom_range(0, 1) ? 16'h7FFF : 16'h8000;
            5: v = $urandom_range(0, span);
            default: return SPEED_W'($urandom);
        endcase
        if ($urandom_range(0, 1))
            v = -v;
        return SPEED_W'(v);
    endfunction

    function automatic t_motor_cmd random_command();
        t_motor_cmd c;
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 45)
            c.req_type = REQ_SPEED;
        else if (pick < 55)
            c.req_type = REQ_STOP;
        else if (pick < 63)
            c.req_type = REQ_BRAKE;
        else if (pick < 78)
            c.req_type = REQ_DIR;
        else if (pick < 93)
            c.req_type = REQ_RAW;
        else
            c.req_type = REQ_W'($urandom_range(int'(REQ_RAW) + 1, (1 << REQ_W) - 1));
        if ($urandom_range(0, 99) < 92)
            c.channel = CHAN_W'($urandom_range(0, CHANNELS_DEF - 1));
        else
            c.channel = CHAN_W'($urandom_range(CHANNELS_DEF, (1 << CHAN_W) - 1));
        c.speed          = pick_speed();
        c.direction_code = DIR_W'($urandom);
        case ($urandom_range(0, 5))
            0:       c.duty_value = '0;
            1:       c.duty_value = '1;
            default: c.duty_value = DUTY_W'($urandom);
        endcase
        return c;
    endfunction

    task automatic write_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
        @(posedge i_clk);
        cfg_bus.valid <= 1'b1;
        cfg_bus.index <= idx;
        cfg_bus.data  <= value;
        do
            @(posedge i_clk);
        while (!(cfg_bus.valid && cfg_bus.ready));
        cfg_bus.valid <= 1'b0;
        case (idx)
            CFG_MAX_RPM:  cfg_max_rpm  = value[RPM_W-1:0];
            CFG_PWM_FULL: cfg_pwm_full = value[DUTY_W-1:0];
            CFG_POLARITY: cfg_polarity = value[POL_W-1:0];
            default: ;
        endcase
    endtask

    // wait for the block to go idle; dropped commands leave no action to wait on
    task automatic drain();
        while (command_backlog.size() != 0 || req_bus.valid || expected_actions.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic run_phase(logic [CFG_DATA_W-1:0] rpm_word, logic [CFG_DATA_W-1:0] duty_word,
                             logic [CFG_DATA_W-1:0] pol_word, int count, int gaps, int stalls);
        write_register(CFG_MAX_RPM, rpm_word);
        write_register(CFG_PWM_FULL, duty_word);
        write_register(CFG_POLARITY, pol_word);
        gap_pct   = gaps;
        stall_pct = stalls;
        repeat (count) command_backlog.push_back(random_command());
        drain();
    endtask

    // command driver
    always @(posedge i_clk) begin : drive_commands
        logic taken;
        taken = req_bus.valid && req_bus.ready;
        if (!i_rst_n) begin
            req_bus.valid <= 1'b0;
        end else begin
            if (taken)
                predict_bridge_actions(command_backlog.pop_front());
            if (req_bus.valid && !taken) begin
                // offered command still waiting
            end else if (send_gap > 0) begin
                send_gap--;
                req_bus.valid <= 1'b0;
            end else if (command_backlog.size() != 0 && $urandom_range(0, 99) < gap_pct) begin
                send_gap = $urandom_range(1, BURST_MAX) - 1;
                req_bus.valid <= 1'b0;
            end else if (command_backlog.size() != 0) begin
                req_bus.valid          <= 1'b1;
                req_bus.req_type       <= command_backlog[0].req_type;
                req_bus.channel        <= command_backlog[0].channel;
                req_bus.speed          <= command_backlog[0].speed;
                req_bus.direction_code <= command_backlog[0].direction_code;
                req_bus.duty_value     <= command_backlog[0].duty_value;
            end else begin
                req_bus.valid <= 1'b0;
            end
        end
    end

    // action monitor and back-pressure
    always @(posedge i_clk) begin : check_actions
        t_bridge_action seen;
        t_bridge_action want;
        if (!i_rst_n) begin
            act_bus.ready <= 1'b0;
        end else begin
            if (act_bus.valid && act_bus.ready) begin
                seen.out_channel = act_bus.out_channel;
                seen.action      = act_bus.action;
                seen.duty        = act_bus.duty;
                seen.pin_in1     = act_bus.pin_in1;
                seen.pin_in2     = act_bus.pin_in2;
                seen.last        = act_bus.last;
                if (expected_actions.size() == 0) begin
                    n_fail++;
                    if (n_fail <= MAX_REPORTS)
                        $display("unexpected action transaction: %s", describe_action(seen));
                end else begin
                    want = expected_actions.pop_front();
                    if (seen !== want) begin
                        n_fail++;
                        if (n_fail <= MAX_REPORTS)
                            $display("action transaction wrong: got %s, expected %s",
                                     describe_action(seen), describe_action(want));
                    end
                end
            end
            if (hold_left > 0) begin
                hold_left--;
                act_bus.ready <= 1'b0;
            end else if ($urandom_range(0, 99) < stall_pct) begin
                hold_left = $urandom_range(1, BURST_MAX) - 1;
                act_bus.ready <= 1'b0;
            end else begin
                act_bus.ready <= 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin
        if ((req_bus.valid && req_bus.ready) || (act_bus.valid && act_bus.ready) ||
            (cfg_bus.valid && cfg_bus.ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles == WATCHDOG_LIMIT) begin
            $display("hbridge_motor_command_sequencer: mismatch");
            $finish;
        end
    end

    initial begin
        i_rst_n                = 1'b0;
        req_bus.valid          = 1'b0;
        req_bus.req_type       = REQ_SPEED;
        req_bus.channel        = '0;
        req_bus.speed          = '0;
        req_bus.direction_code = MODE_STOP;
        req_bus.duty_value     = '0;
        act_bus.ready          = 1'b0;
        cfg_bus.valid          = 1'b0;
        cfg_bus.index          = CFG_MAX_RPM;
        cfg_bus.data           = '0;
        foreach (bridge_state[i])
            bridge_state[i] = MODE_STOP;
        cfg_max_rpm  = RPM_RESET;
        cfg_pwm_full = DUTY_RESET;
        cfg_polarity = POL_RESET;
        send_gap     = 0;
        hold_left    = 0;
        gap_pct      = 30;
        stall_pct    = 10;
        n_fail       = 0;
        quiet_cycles = 0;

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reset register values: max_rpm and PWM full scale both 1000, no reversal
        command_backlog.push_back(make_command(REQ_SPEED, 0, 500, MODE_STOP, 0));
        command_backlog.push_back(make_command(REQ_SPEED, 0, 1000, MODE_STOP, 0));
        command_backlog.push_back(make_command(REQ_SPEED, 0, 32767, MODE_STOP, 0));
        command_backlog.push_back(make_command(REQ_SPEED, 0, -32768, MODE_STOP, 0));
        command_backlog.push_back(make_command(REQ_SPEED, 0, -1, MODE_STOP, 0));
        command_backlog.push_back(make_command(REQ_SPEED, 0, 0, MODE_STOP, 0));
        command_backlog.push_back(make_command(REQ_SPEED, 0, 0, MODE_STOP, 0));
        command_backlog.push_back(make_command(REQ_STOP, 1, 0, MODE_STOP, 0));
        command_backlog.push_back(make_command(REQ_BRAKE, 1, 0, MODE_STOP, 0));
        command_backlog.push_back(make_command(REQ_SPEED, 1, 3, MODE_STOP, 0));
        command_backlog.push_back(make_command(REQ_DIR, 2, 0, MODE_STOP, 0));
        command_backlog.push_back(make_command(REQ_DIR, 2, 0, MODE_FWD, 0));
        command_backlog.push_back(make_command(REQ_DIR, 2, 0, MODE_BWD, 0));
        command_backlog.push_back(make_command(REQ_DIR, 2, 0, MODE_BRAKE, 0));
        command_backlog.push_back(make_command(REQ_SPEED, 2, -999, MODE_STOP, 0));
        command_backlog.push_back(make_command(REQ_RAW, 3, 0, MODE_STOP, 0));
        command_backlog.push_back(make_command(REQ_RAW, 3, 65535, MODE_STOP, 0));
        command_backlog.push_back(make_command(REQ_SPEED, 3, 1, MODE_STOP, 0));
        command_backlog.push_back(make_command(REQ_SPEED, 4, 500, MODE_STOP, 0));
        command_backlog.push_back(make_command(REQ_STOP, 7, 0, MODE_STOP, 0));
        command_backlog.push_back(make_command(REQ_W'(int'(REQ_RAW) + 1), 0, 0, MODE_STOP, 1));
        command_backlog.push_back(make_command({REQ_W{1'b1}}, 3, 0, MODE_BRAKE, 1));
        command_backlog.push_back(make_command(REQ_DIR, 3, 0, MODE_FWD, 0));
        command_backlog.push_back(make_command(REQ_SPEED, 3, 1000, MODE_STOP, 0));
        command_backlog.push_back(make_command(REQ_BRAKE, 0, 0, MODE_STOP, 0));
        drain();

        run_phase(16'd1, 16'hFFFF, 16'hFFFF, 50, 30, 10);
        run_phase(16'h7FFF, 16'd1, 16'h0000, 50, 0, 25);
        // max_rpm of zero, reached through the unused top bit, acts as one
        run_phase(16'h8000, 16'd1, 16'h0005, 50, 40, 0);
        run_phase(16'hFFFF, 16'hFFFF, 16'hFFFA, 50, 20, 15);
        run_phase(16'($urandom_range(1, 2000)), 16'($urandom), 16'($urandom), 50, 30, 10);
        write_register(CFG_SPARE, 16'($urandom));
        run_phase(16'($urandom), 16'($urandom), 16'($urandom), 50, 15, 30);
        run_phase(16'($urandom_range(1, 300)), 16'($urandom_range(1, 5000)),
                  16'($urandom), 50, 30, 10);
        // closing stretch at full rate on both sides
        run_phase(16'($urandom_range(1, 4000)), 16'($urandom), 16'($urandom), 50, 0, 0);

        if (n_fail == 0 && expected_actions.size() == 0)
            $display("hbridge_motor_command_sequencer: match");
        else
            $display("hbridge_motor_command_sequencer: mismatch");
        $finish;
    end

endmodule

// ===== hbridge_motor_command_sequencer.f =====
rtl/hmcs_pkg.sv
rtl/hmcs_if.sv
rtl/hmcs_dp.sv
rtl/hmcs_ctrl.sv
rtl/hbridge_motor_command_sequencer.sv
dv/testbench.sv
